>>> hdl/eic_pkg.sv
// eic_pkg: shared constants, codes, types and the priority encoder for the
// external interrupt edge controller. Depends on nothing.
package eic_pkg;

  localparam int unsigned DEF_CHANNELS = 32;
  localparam int unsigned DEF_GROUPS   = 4;

  localparam int unsigned FIELD_W      = 32;
  localparam int unsigned LINES_W      = 4;
  localparam int unsigned CHAN_IDX_W   = 5;
  localparam int unsigned GROUP_SIZE   = 8;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned CFG_IDX_W    = 2;

  // op codes of an input item
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_STATUS = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RISE_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_ENABLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_ENABLE = 2'd2;

  typedef struct packed {
    logic [FIELD_W-1:0] last_levels;
    logic [FIELD_W-1:0] pending;
  } eic_state_t;

  typedef struct packed {
    logic [FIELD_W-1:0]    pending;
    logic [LINES_W-1:0]    request_lines;
    logic                  request_any;
    logic [CHAN_IDX_W-1:0] first_channel;
    logic                  first_valid;
  } eic_result_t;

  // lowest set bit, zero when none
  function automatic logic [CHAN_IDX_W-1:0] lowest_set(input logic [FIELD_W-1:0] v);
    logic [CHAN_IDX_W-1:0] idx;
    idx = '0;
    for (int i = FIELD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = CHAN_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> hdl/eic_channels.sv
// eic_channels: valid/ready channel interfaces for items, results and
// configuration writes. Depends on eic_pkg.
interface eic_in_if import eic_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [FIELD_W-1:0] pin_levels;
  logic [FIELD_W-1:0] clear_mask;

  modport source (output valid, op, pin_levels, clear_mask, input ready);
  modport sink   (input valid, op, pin_levels, clear_mask, output ready);
endinterface

interface eic_out_if import eic_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_W-1:0]    pending;
  logic [LINES_W-1:0]    request_lines;
  logic                  request_any;
  logic [CHAN_IDX_W-1:0] first_channel;
  logic                  first_valid;

  modport source (output valid, pending, request_lines, request_any, first_channel,
                  first_valid, input ready);
  modport sink   (input valid, pending, request_lines, request_any, first_channel,
                  first_valid, output ready);
endinterface

interface eic_cfg_if import eic_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIELD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/external_irq_edge_controller.sv
// external_irq_edge_controller: top level of the 32-channel edge-triggered
// interrupt unit. Depends on eic_pkg, eic_channels and eic_eval.
//
// Usage
//   in_ch  : one item per handshake; op selects sample pins, status read or
//            write-one-to-clear of the pending flags
//   out_ch : one result per item, in order: pending flags, one request line
//            per group of eight channels, any-request and lowest channel
//   cfg_ch : register writes (rise enable, fall enable, request enable);
//            always ready, only to be used while no item is in flight
// Timing
//   an item is registered into the input stage on acceptance and evaluated from
//   there into the result register once that register is free or being taken
//   one item per cycle sustained while out_ch takes each result; the single
//   evaluation step that reads and updates the edge and pending state sets that rate
// Reset
//   rst_n clears the enables, the last pin sample and all pending flags and
//   empties both stages; the first sample is compared against all zero
// Stall
//   a held result keeps its payload; the input stage still takes one item
//   while the result waits, then in_ch.ready drops until out_ch moves
module external_irq_edge_controller import eic_pkg::*; #(
  parameter int unsigned CHANNELS = DEF_CHANNELS,
  parameter int unsigned GROUPS   = DEF_GROUPS
) (
  input  logic      clk,
  input  logic      rst_n,
  eic_in_if.sink    in_ch,
  eic_out_if.source out_ch,
  eic_cfg_if.sink   cfg_ch
);

  localparam logic [FIELD_W-1:0] CHAN_MASK = (CHANNELS >= FIELD_W) ? {FIELD_W{1'b1}} :
                                             ((FIELD_W'(1) << CHANNELS) - FIELD_W'(1));

  // configuration registers
  logic [FIELD_W-1:0] rise_en_r;
  logic [FIELD_W-1:0] fall_en_r;
  logic [FIELD_W-1:0] req_en_r;

  // edge and pending state
  eic_state_t state_r;
  eic_state_t state_nxt;

  // input stage
  logic               s1_valid_r;
  logic [OP_W-1:0]    s1_op_r;
  logic [FIELD_W-1:0] s1_pins_r;
  logic [FIELD_W-1:0] s1_clear_r;

  // result stage
  logic        out_valid_r;
  eic_result_t out_res_r;
  eic_result_t res_nxt;

  logic s1_adv;
  logic in_take;

  // the result register frees when empty or being taken this cycle
  assign s1_adv  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign cfg_ch.ready = 1'b1;

  eic_eval #(
    .CHANNELS (CHANNELS),
    .GROUPS   (GROUPS)
  ) u_eval (
    .op             (s1_op_r),
    .pin_levels     (s1_pins_r),
    .clear_mask     (s1_clear_r),
    .rise_enable    (rise_en_r),
    .fall_enable    (fall_en_r),
    .request_enable (req_en_r),
    .state          (state_r),
    .state_nxt      (state_nxt),
    .result         (res_nxt)
  );

  // register writes, masked to the live channels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_en_r <= '0;
      fall_en_r <= '0;
      req_en_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_RISE_ENABLE:    rise_en_r <= cfg_ch.data & CHAN_MASK;
        REG_FALL_ENABLE:    fall_en_r <= cfg_ch.data & CHAN_MASK;
        REG_REQUEST_ENABLE: req_en_r  <= cfg_ch.data & CHAN_MASK;
        default: begin
        end
      endcase
    end
  end

  // state moves only when an item leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r    <= in_ch.op;
      s1_pins_r  <= in_ch.pin_levels;
      s1_clear_r <= in_ch.clear_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pending       = out_res_r.pending;
  assign out_ch.request_lines = out_res_r.request_lines;
  assign out_ch.request_any   = out_res_r.request_any;
  assign out_ch.first_channel = out_res_r.first_channel;
  assign out_ch.first_valid   = out_res_r.first_valid;

endmodule

>>> hdl/eic_eval.sv
// eic_eval: edge detection, pending update and request reporting for one
// item, purely combinational. Depends on eic_pkg.
module eic_eval import eic_pkg::*; #(
  parameter int unsigned CHANNELS = DEF_CHANNELS,
  parameter int unsigned GROUPS   = DEF_GROUPS
) (
  input  logic [OP_W-1:0]    op,
  input  logic [FIELD_W-1:0] pin_levels,
  input  logic [FIELD_W-1:0] clear_mask,
  input  logic [FIELD_W-1:0] rise_enable,
  input  logic [FIELD_W-1:0] fall_enable,
  input  logic [FIELD_W-1:0] request_enable,
  input  eic_state_t         state,
  output eic_state_t         state_nxt,
  output eic_result_t        result
);

  localparam logic [FIELD_W-1:0] CHAN_MASK = (CHANNELS >= FIELD_W) ? {FIELD_W{1'b1}} :
                                             ((FIELD_W'(1) << CHANNELS) - FIELD_W'(1));
  localparam int unsigned FIT_GROUPS = FIELD_W / GROUP_SIZE;
  localparam int unsigned LINE_CAP   = (LINES_W < FIT_GROUPS) ? LINES_W : FIT_GROUPS;
  localparam int unsigned LIVE_LINES = (GROUPS < LINE_CAP) ? GROUPS : LINE_CAP;

  logic [FIELD_W-1:0] pins;
  logic [FIELD_W-1:0] hits;
  logic [FIELD_W-1:0] req;

  always_comb begin
    pins      = pin_levels & CHAN_MASK;
    hits      = ((pins & ~state.last_levels) & rise_enable) |
                ((~pins & state.last_levels) & fall_enable);
    state_nxt = state;
    case (op)
      OP_SAMPLE: begin
        state_nxt.pending     = state.pending | hits;
        state_nxt.last_levels = pins;
      end
      OP_CLEAR: begin
        state_nxt.pending = state.pending & ~clear_mask;
      end
      default: begin
        state_nxt = state;
      end
    endcase
    state_nxt.pending = state_nxt.pending & CHAN_MASK;

    req                  = state_nxt.pending & request_enable & CHAN_MASK;
    result.pending       = state_nxt.pending;
    result.request_lines = '0;
    for (int g = 0; g < LIVE_LINES; g++) begin
      result.request_lines[g] = |req[g*GROUP_SIZE +: GROUP_SIZE];
    end
    result.request_any   = |req;
    result.first_valid   = |req;
    result.first_channel = lowest_set(req);
  end

endmodule

>>> hdl/eic_checker.sv
// eic_checker: port-level assertions for the external interrupt edge
// controller, bound to the top level. Depends on eic_pkg.
module eic_checker import eic_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [FIELD_W-1:0]    pending,
  input logic [LINES_W-1:0]    request_lines,
  input logic                  request_any,
  input logic [CHAN_IDX_W-1:0] first_channel,
  input logic                  first_valid
);

  // a stalled result holds still
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pending) &&
      $stable(request_lines) && $stable(first_channel) && $stable(request_any))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> request_any == first_valid)
    else $error("request_any and first_valid disagree");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !request_any |-> first_channel == '0 && request_lines == '0)
    else $error("request reported with no request active");

  // the named channel must itself be pending
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_valid |-> pending[first_channel])
    else $error("first channel not pending");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result present straight after reset");

endmodule

bind external_irq_edge_controller eic_checker u_eic_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .pending       (out_ch.pending),
  .request_lines (out_ch.request_lines),
  .request_any   (out_ch.request_any),
  .first_channel (out_ch.first_channel),
  .first_valid   (out_ch.first_valid)
);
